/* src/timing_wheel_scheduler_assert.svh */
// Assertion macros for the timing wheel scheduler RTL.
// Included by twsch_dp, which checks its own logic; no other dependencies.
`ifndef TIMING_WHEEL_SCHEDULER_ASSERT_SVH
`define TIMING_WHEEL_SCHEDULER_ASSERT_SVH

// Check a property at every clock edge outside reset
`define TWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every clock edge, reset included
`define TWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/twsch_pkg.sv */
// Package for the timing wheel scheduler: field widths, event codes,
// controller states and the command/status structs between the modules.
`default_nettype none
package twsch_pkg;

    localparam int ACT_W   = 7;   // slots_in_use register width
    localparam int ID_W    = 8;
    localparam int RUN_W   = 16;
    localparam int PER_W   = 16;
    localparam int TIME_W  = 32;
    localparam int SLOTO_W = 6;   // slot_index field width
    localparam int STEP_W  = 6;   // divider step count width
    localparam int REM_W   = 16;  // divider remainder width
    localparam int MOD_STEPS = 32;
    localparam int REL_STEPS = ACT_W;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 40;

    typedef enum logic [2:0] {
        EV_FIRED         = 3'd0,
        EV_FIRED_RETIRED = 3'd1,
        EV_RETIRED       = 3'd2,
        EV_ACCEPTED      = 3'd3,
        EV_REJECTED      = 3'd4
    } ev_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_MOD,
        ST_A_MODW,
        ST_A_FILL,
        ST_A_CHK,
        ST_A_DIVW,
        ST_A_SHRD,
        ST_A_SHWR,
        ST_A_NEW,
        ST_A_RES,
        ST_T_FILL,
        ST_T_CHK,
        ST_T_RD,
        ST_T_PROC,
        ST_T_DIVW,
        ST_T_UPD,
        ST_T_END
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [RUN_W-1:0] runs;
        logic [ACT_W-1:0] cd;
        logic [PER_W-1:0] period;
    } entry_t;

    typedef struct packed {
        logic clr_wr;
        logic load_in;
        logic div_mod_start;
        logic div_rel_start;
        logic slot_from_rem;
        logic fill_rd;
        logic fill_latch;
        logic cd_from_q;
        logic sh_rd;
        logic sh_wr;
        logic wr_new;
        logic add_res;
        logic ent_rd;
        logic ent_upd;
        logic tick_end;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic reject;
        logic j_zero;
        logic i_end;
        logic fired;
        logic out_free;
        logic pend_valid;
    } dp_sts_t;

endpackage
`default_nettype wire

/* src/timing_wheel_scheduler.sv */
// Top level of the timing wheel scheduler: APB register, controller, datapath.
// Depends on twsch_pkg, twsch_ctrl and twsch_dp.
//
// Hashed timing wheel. After reset the block sweeps the slot fill table, one
// slot per cycle, before it takes its first transfer. Items are handled one
// at a time. A stored add runs a 32-step divider loop that hashes the time
// stamp to a slot and a 7-step pass that computes the reload count, then
// shifts the slot list one entry at a time through the task memory, which
// has one read port and one write port. A rejected add skips the reload pass
// and the shift. A tick walks the tasks of the current slot and runs the
// reload division for each task that fires; results stall only when the
// output register is full.
`default_nettype none
module timing_wheel_scheduler
    import twsch_pkg::*;
#(
    parameter int MAX_SLOTS      = 64,
    parameter int TASKS_PER_SLOT = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // kind
    input  wire logic [0:0]       s_tuser,
    // task_id, add_time, period, exec_count
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // event_res, task_out, runs_left, slot_index
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [ACT_W-1:0] slots_reg;
    logic [ACT_W-1:0] active;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    // Slot count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= ACT_W'(64);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            slots_reg <= pwdata[ACT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {25'd0, slots_reg};

    // Clamp the slot count to between 2 and the wheel size
    always_comb begin
        if (slots_reg < ACT_W'(2)) begin
            active = ACT_W'(2);
        end else if (32'(slots_reg) > MAX_SLOTS) begin
            active = ACT_W'(MAX_SLOTS);
        end else begin
            active = slots_reg;
        end
    end

    twsch_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    twsch_dp #(
        .MAX_SLOTS      (MAX_SLOTS),
        .TASKS_PER_SLOT (TASKS_PER_SLOT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .active    (active),
        .in_kind   (s_tuser[0]),
        .in_id     (s_tdata[7:0]),
        .in_time   (s_tdata[39:8]),
        .in_period (s_tdata[55:40]),
        .in_runs   (s_tdata[71:56]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

/* src/twsch_div.sv */
// Restoring divider, one quotient bit per cycle, step count set at start.
// Uses twsch_pkg for widths.
`default_nettype none
module twsch_div
    import twsch_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] dividend,
    input  wire logic [REM_W-1:0]  divisor,
    input  wire logic [STEP_W-1:0] steps,
    output logic                   busy,
    output logic [TIME_W-1:0]      quot,
    output logic [REM_W-1:0]       rem
);

    logic [TIME_W-1:0] q_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dvsr_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;

    // Trial subtract of the shifted partial remainder
    assign trial = {rem_reg, q_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign ge    = (trial >= {1'b0, dvsr_reg});

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Quotient and remainder; hold the divisor for the whole run
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[TIME_W-2:0], ge};
            rem_reg <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

/* src/twsch_ctrl.sv */
// Controller state machine of the timing wheel scheduler.
// Uses twsch_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
`default_nettype none
module twsch_ctrl
    import twsch_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    input  wire logic    s_kind,
    output logic         s_tready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = s_kind ? ST_A_MOD : ST_T_FILL;
                end
            end
            ST_A_MOD: begin
                cmd.div_mod_start = 1'b1;
                state_next        = ST_A_MODW;
            end
            ST_A_MODW: begin
                if (!sts.div_busy) begin
                    cmd.slot_from_rem = 1'b1;
                    state_next        = ST_A_FILL;
                end
            end
            ST_A_FILL: begin
                cmd.fill_rd = 1'b1;
                state_next  = ST_A_CHK;
            end
            ST_A_CHK: begin
                cmd.fill_latch = 1'b1;
                if (sts.reject) begin
                    state_next = ST_A_RES;
                end else begin
                    cmd.div_rel_start = 1'b1;
                    state_next        = ST_A_DIVW;
                end
            end
            ST_A_DIVW: begin
                if (!sts.div_busy) begin
                    cmd.cd_from_q = 1'b1;
                    state_next    = ST_A_SHRD;
                end
            end
            ST_A_SHRD: begin
                if (sts.j_zero) begin
                    state_next = ST_A_NEW;
                end else begin
                    cmd.sh_rd  = 1'b1;
                    state_next = ST_A_SHWR;
                end
            end
            ST_A_SHWR: begin
                cmd.sh_wr  = 1'b1;
                state_next = ST_A_SHRD;
            end
            ST_A_NEW: begin
                cmd.wr_new = 1'b1;
                state_next = ST_A_RES;
            end
            ST_A_RES: begin
                if (sts.out_free) begin
                    cmd.add_res = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_T_FILL: begin
                cmd.fill_rd = 1'b1;
                state_next  = ST_T_CHK;
            end
            ST_T_CHK: begin
                cmd.fill_latch = 1'b1;
                state_next     = ST_T_RD;
            end
            ST_T_RD: begin
                if (sts.i_end) begin
                    state_next = ST_T_END;
                end else begin
                    cmd.ent_rd = 1'b1;
                    state_next = ST_T_PROC;
                end
            end
            ST_T_PROC: begin
                if (sts.fired) begin
                    cmd.div_rel_start = 1'b1;
                    state_next        = ST_T_DIVW;
                end else begin
                    state_next = ST_T_UPD;
                end
            end
            ST_T_DIVW: begin
                if (!sts.div_busy) begin
                    state_next = ST_T_UPD;
                end
            end
            ST_T_UPD: begin
                if (!sts.pend_valid || sts.out_free) begin
                    cmd.ent_upd = 1'b1;
                    state_next  = ST_T_RD;
                end
            end
            ST_T_END: begin
                if (!sts.pend_valid || sts.out_free) begin
                    cmd.tick_end = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/twsch_dp.sv */
// Datapath of the timing wheel scheduler: slot fill and task memories,
// list counters, wheel pointer, result registers. Uses twsch_pkg, twsch_div.
`default_nettype none
`include "timing_wheel_scheduler_assert.svh"
module twsch_dp
    import twsch_pkg::*;
#(
    parameter int MAX_SLOTS      = 64,
    parameter int TASKS_PER_SLOT = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_cmd_t           cmd,
    output dp_sts_t                sts,
    input  wire logic [ACT_W-1:0]  active,
    input  wire logic              in_kind,
    input  wire logic [ID_W-1:0]   in_id,
    input  wire logic [TIME_W-1:0] in_time,
    input  wire logic [PER_W-1:0]  in_period,
    input  wire logic [RUN_W-1:0]  in_runs,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    output logic                   m_tlast
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IDX_W  = (TASKS_PER_SLOT > 1) ? $clog2(TASKS_PER_SLOT) : 1;
    localparam int FILL_W = $clog2(TASKS_PER_SLOT + 1);
    localparam int DEPTH  = MAX_SLOTS * (2 ** IDX_W);

    typedef struct packed {
        ev_t              ev;
        logic [ID_W-1:0]  id;
        logic [RUN_W-1:0] runs;
    } res_t;

    // Memories
    logic [FILL_W-1:0] fill_mem [MAX_SLOTS];
    entry_t            task_mem [DEPTH];
    logic [FILL_W-1:0] fill_q;
    entry_t            ent_q;

    // Item and walk registers
    logic              kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;
    logic [PER_W-1:0]  per_reg;
    logic [RUN_W-1:0]  runs_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] ptr_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] i_reg;
    logic [FILL_W-1:0] w_reg;
    logic [FILL_W-1:0] j_reg;
    logic [ACT_W-1:0]  cd_reg;
    logic              rej_reg;

    // Pending and output results
    res_t              pend_reg;
    logic              pend_valid_reg;
    res_t              out_reg;
    logic              out_last_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              m_tvalid_reg;

    // Divider
    logic              div_start;
    logic [TIME_W-1:0] div_dividend;
    logic [REM_W-1:0]  div_divisor;
    logic [STEP_W-1:0] div_steps;
    logic              div_busy;
    logic [TIME_W-1:0] div_quot;
    logic [REM_W-1:0]  div_rem;

    // Walk decision for the entry under read
    logic              fired;
    logic [RUN_W-1:0]  runs_new;
    logic [ACT_W-1:0]  cd_new;
    logic              retire;
    logic              has_res;
    res_t              walk_res;
    logic              reject;
    logic              out_free;
    logic [FILL_W-1:0] j_dec;
    logic [SLOT_W:0]   ptr_inc;

    // Memory port controls
    logic              fill_we;
    logic [SLOT_W-1:0] fill_waddr;
    logic [FILL_W-1:0] fill_wdata;
    logic              task_we;
    logic [IDX_W-1:0]  task_widx;
    entry_t            task_wdata;
    logic              task_re;
    logic [IDX_W-1:0]  task_ridx;
    logic [SLOT_W+SLOTO_W-1:0] slot_ext;

    assign div_start    = cmd.div_mod_start | cmd.div_rel_start;
    assign div_dividend = cmd.div_mod_start ? time_reg
                                            : {active, (TIME_W - ACT_W)'(0)};
    assign div_divisor  = cmd.div_mod_start ? REM_W'(active)
                        : (kind_reg ? per_reg : ent_q.period);
    assign div_steps    = cmd.div_mod_start ? STEP_W'(MOD_STEPS) : STEP_W'(REL_STEPS);

    twsch_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Fire, count down and retire decision
    always_comb begin
        fired    = (ent_q.cd == '0);
        runs_new = ent_q.runs;
        if (fired && ent_q.runs != '0) begin
            runs_new = ent_q.runs - 1'b1;
        end
        cd_new   = fired ? div_quot[ACT_W-1:0] : ent_q.cd - 1'b1;
        retire   = (runs_new == '0);
        has_res  = fired | retire;
        walk_res.id   = ent_q.id;
        walk_res.runs = runs_new;
        if (retire) begin
            walk_res.ev = fired ? EV_FIRED_RETIRED : EV_RETIRED;
        end else begin
            walk_res.ev = EV_FIRED;
        end
    end

    assign reject   = (per_reg == '0) || (32'(fill_q) >= TASKS_PER_SLOT);
    assign out_free = !m_tvalid_reg || m_tready;
    assign j_dec    = j_reg - 1'b1;
    assign ptr_inc  = {1'b0, slot_reg} + 1'b1;

    // Fill memory port selection
    always_comb begin
        fill_we    = cmd.clr_wr | cmd.wr_new | cmd.tick_end;
        fill_waddr = slot_reg;
        fill_wdata = w_reg;
        priority if (cmd.clr_wr) begin
            fill_waddr = clr_reg;
            fill_wdata = '0;
        end else if (cmd.wr_new) begin
            fill_wdata = fill_reg + 1'b1;
        end else begin
            fill_wdata = w_reg;
        end
    end

    // Task memory port selection
    always_comb begin
        task_we    = cmd.sh_wr | cmd.wr_new | (cmd.ent_upd & !retire);
        task_widx  = w_reg[IDX_W-1:0];
        task_wdata = ent_q;
        priority if (cmd.sh_wr) begin
            task_widx = j_reg[IDX_W-1:0];
        end else if (cmd.wr_new) begin
            task_widx         = '0;
            task_wdata.id     = id_reg;
            task_wdata.runs   = runs_reg;
            task_wdata.cd     = cd_reg;
            task_wdata.period = per_reg;
        end else begin
            task_wdata.runs = runs_new;
            task_wdata.cd   = cd_new;
        end
        task_re   = cmd.sh_rd | cmd.ent_rd;
        task_ridx = cmd.sh_rd ? j_dec[IDX_W-1:0] : i_reg[IDX_W-1:0];
    end

    // Slot fill memory
    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (cmd.fill_rd) begin
            fill_q <= fill_mem[slot_reg];
        end
    end

    // Task entry memory
    always_ff @(posedge aclk) begin
        if (task_we) begin
            task_mem[{slot_reg, task_widx}] <= task_wdata;
        end
        if (task_re) begin
            ent_q <= task_mem[{slot_reg, task_ridx}];
        end
    end

    // Control registers: clear sweep, wheel pointer, result valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg        <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.clr_wr) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.add_res) begin
                m_tvalid_reg <= 1'b1;
            end
            if (cmd.ent_upd && has_res) begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg) begin
                    m_tvalid_reg <= 1'b1;
                end
            end
            if (cmd.tick_end) begin
                pend_valid_reg <= 1'b0;
                if (pend_valid_reg) begin
                    m_tvalid_reg <= 1'b1;
                end
                if (32'(ptr_inc) >= 32'(active)) begin
                    ptr_reg <= '0;
                end else begin
                    ptr_reg <= ptr_inc[SLOT_W-1:0];
                end
            end
        end
    end

    // Item, walk and result payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= in_kind;
            id_reg   <= in_id;
            time_reg <= in_time;
            per_reg  <= in_period;
            runs_reg <= in_runs;
            slot_reg <= ptr_reg;
        end
        if (cmd.slot_from_rem) begin
            slot_reg <= div_rem[SLOT_W-1:0];
        end
        if (cmd.fill_latch) begin
            fill_reg <= fill_q;
            rej_reg  <= reject;
            i_reg    <= '0;
            w_reg    <= '0;
            j_reg    <= fill_q;
        end
        if (cmd.cd_from_q) begin
            cd_reg <= div_quot[ACT_W-1:0];
        end
        if (cmd.sh_wr) begin
            j_reg <= j_dec;
        end
        if (cmd.ent_upd) begin
            i_reg <= i_reg + 1'b1;
            if (!retire) begin
                w_reg <= w_reg + 1'b1;
            end
            if (has_res) begin
                pend_reg <= walk_res;
                if (pend_valid_reg) begin
                    out_reg      <= pend_reg;
                    out_last_reg <= 1'b0;
                    out_slot_reg <= slot_reg;
                end
            end
        end
        if (cmd.tick_end && pend_valid_reg) begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
            out_slot_reg <= slot_reg;
        end
        if (cmd.add_res) begin
            out_reg.ev   <= rej_reg ? EV_REJECTED : EV_ACCEPTED;
            out_reg.id   <= id_reg;
            out_reg.runs <= runs_reg;
            out_last_reg <= 1'b1;
            out_slot_reg <= slot_reg;
        end
    end

    // Status to the controller
    always_comb begin
        sts.clr_done   = (clr_reg == SLOT_W'(MAX_SLOTS - 1));
        sts.div_busy   = div_busy;
        sts.reject     = reject;
        sts.j_zero     = (j_reg == '0);
        sts.i_end      = (i_reg == fill_reg);
        sts.fired      = fired;
        sts.out_free   = out_free;
        sts.pend_valid = pend_valid_reg;
    end

    // Result port
    assign slot_ext = {SLOTO_W'(0), out_slot_reg};
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, slot_ext[SLOTO_W-1:0], out_reg.runs, out_reg.id, out_reg.ev};

    `TWS_ASSERT(a_div_idle_on_start, div_start |-> !div_busy, "divider started while busy")
    `TWS_ASSERT(a_tick_end_flush, cmd.tick_end |=> !pend_valid_reg, "pending result kept")
    `TWS_ASSERT(a_fill_bound, fill_we |-> (32'(fill_wdata) <= TASKS_PER_SLOT), "fill overflow")
    `TWS_ASSERT(a_compact_order, cmd.ent_upd |-> (w_reg <= i_reg), "compaction overtook walk")
    `TWS_ASSERT_ALWAYS(a_reset_out, !aresetn |=> !m_tvalid_reg, "result valid after reset")

endmodule
`default_nettype wire

/* dv/timing_wheel_scheduler_test.sv */
// Self-checking testbench for the timing wheel scheduler: stream stimulus,
// APB slot-count writes and a scoreboard with its own wheel predictor.
// Depends on twsch_pkg and the timing_wheel_scheduler RTL.
`timescale 1ns / 1ps

module timing_wheel_scheduler_test
    import twsch_pkg::*;
;

    typedef struct {
        ev_t        ev;
        logic [7:0] id;
        logic [15:0] runs;
        logic [5:0] slot;
        bit         last;
    } wheel_event_t;

    class wheel_scoreboard;
        int unsigned slots_reg;
        int unsigned wheel_ptr;
        int unsigned fill[64];
        int unsigned t_id[64][8];
        int unsigned t_runs[64][8];
        int unsigned t_cd[64][8];
        int unsigned t_per[64][8];
        wheel_event_t pending_events[$];
        int errors;

        function void reset_state();
            slots_reg = 64;
            wheel_ptr = 0;
            foreach (fill[i]) fill[i] = 0;
            pending_events.delete();
            errors = 0;
        endfunction

        function int unsigned live_slots();
            if (slots_reg < 2) return 2;
            if (slots_reg > 64) return 64;
            return slots_reg;
        endfunction

        function int unsigned reload(int unsigned per);
            return (per == 0) ? 0 : live_slots() / per;
        endfunction

        function void push_event(ev_t ev, int unsigned id, int unsigned runs,
                                 int unsigned slot);
            wheel_event_t e;
            e.ev = ev;
            e.id = id[7:0];
            e.runs = runs[15:0];
            e.slot = slot[5:0];
            e.last = 0;
            pending_events.push_back(e);
        endfunction

        // Work out the events caused by one accepted transfer
        function void note_item(bit is_add, logic [71:0] d);
            int unsigned id, at, per, ex, slot, n, f, i, k;
            bit fired;
            id = 32'(d[7:0]);
            at = d[39:8];
            per = 32'(d[55:40]);
            ex = 32'(d[71:56]);
            n = pending_events.size();
            if (is_add) begin
                slot = at % live_slots();
                if (per == 0 || fill[slot] >= 8) begin
                    push_event(EV_REJECTED, id, ex, slot);
                end else begin
                    // newest task goes to the head of the list
                    for (k = fill[slot]; k > 0; k--) begin
                        t_id[slot][k] = t_id[slot][k-1];
                        t_runs[slot][k] = t_runs[slot][k-1];
                        t_cd[slot][k] = t_cd[slot][k-1];
                        t_per[slot][k] = t_per[slot][k-1];
                    end
                    t_id[slot][0] = id;
                    t_runs[slot][0] = ex;
                    t_per[slot][0] = per;
                    t_cd[slot][0] = reload(per);
                    fill[slot]++;
                    push_event(EV_ACCEPTED, id, ex, slot);
                end
            end else begin
                slot = wheel_ptr % 64;
                f = fill[slot];
                i = 0;
                while (i < f) begin
                    fired = 0;
                    if (t_cd[slot][i] == 0) begin
                        fired = 1;
                        if (t_runs[slot][i] > 0) t_runs[slot][i]--;
                        t_cd[slot][i] = reload(t_per[slot][i]);
                    end else begin
                        t_cd[slot][i]--;
                    end
                    if (t_runs[slot][i] == 0) begin
                        push_event(fired ? EV_FIRED_RETIRED : EV_RETIRED,
                                   t_id[slot][i], 0, slot);
                        // drop the retired entry, close the gap
                        for (k = i; k + 1 < f; k++) begin
                            t_id[slot][k] = t_id[slot][k+1];
                            t_runs[slot][k] = t_runs[slot][k+1];
                            t_cd[slot][k] = t_cd[slot][k+1];
                            t_per[slot][k] = t_per[slot][k+1];
                        end
                        f--;
                    end else begin
                        if (fired) push_event(EV_FIRED, t_id[slot][i], t_runs[slot][i], slot);
                        i++;
                    end
                end
                fill[slot] = f;
                wheel_ptr = slot + 1;
                if (wheel_ptr >= live_slots()) wheel_ptr = 0;
            end
            if (pending_events.size() > n) pending_events[pending_events.size()-1].last = 1;
        endfunction

        // Compare one result transfer with the oldest expected event
        function void check_result(logic [39:0] d, logic lst);
            wheel_event_t e;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b", $time, d, lst);
                errors++;
                return;
            end
            e = pending_events.pop_front();
            if (d[2:0] !== e.ev) begin
                $display("%0t: event_res expected %0d actual %0d", $time, e.ev, d[2:0]);
                errors++;
            end
            if (d[10:3] !== e.id) begin
                $display("%0t: task_out expected %0d actual %0d", $time, e.id, d[10:3]);
                errors++;
            end
            if (d[26:11] !== e.runs) begin
                $display("%0t: runs_left expected %0d actual %0d", $time, e.runs, d[26:11]);
                errors++;
            end
            if (d[32:27] !== e.slot) begin
                $display("%0t: slot_index expected %0d actual %0d", $time, e.slot, d[32:27]);
                errors++;
            end
            if (d[39:33] !== 7'd0) begin
                $display("%0t: pad bits expected 0 actual %h", $time, d[39:33]);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic [0:0]  s_tuser = 0;   // kind
    logic [71:0] s_tdata = 0;   // task_id, add_time, period, exec_count
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] m_tdata;       // event_res, task_out, runs_left, slot_index
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    wheel_scoreboard sb = new();
    int burst_left = 0;
    int hold_request = 0;
    int hold_count = 0;
    int ready_mode = 0;
    int idle_cycles = 0;
    int unsigned phase_values[7] = '{4, 2, 0, 7, 127, 13, 64};

    timing_wheel_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tuser(s_tuser), .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // Receiver: check results, stall on a pattern that changes at random, hold ready low on request
    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            if ($urandom_range(63) == 0) ready_mode = $urandom_range(2);
            if (hold_count > 0) begin
                hold_count--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 0;
                hold_count = 400;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(1));
                    default: m_tready <= ($urandom_range(3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.slots_reg = value[6:0];
    endtask

    // Offer one transfer; the sender works in bursts with random gaps
    task automatic send_item(input bit is_add, input logic [71:0] d);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge aclk);
            burst_left = $urandom_range(16, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= is_add;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(is_add, d);
    endtask

    task automatic send_add(input logic [7:0] id, input logic [31:0] at,
                            input logic [15:0] per, input logic [15:0] ex);
        send_item(1'b1, {ex, per, at, id});
    endtask

    task automatic send_tick();
        send_item(1'b0, {$urandom, $urandom, 8'($urandom)});
    endtask

    task automatic random_item(input int unsigned slots);
        logic [15:0] per, ex;
        if ($urandom_range(9) < 4) begin
            send_tick();
        end else begin
            case ($urandom_range(9))
                0: per = 16'($urandom);
                1: per = 0;
                default: per = 16'($urandom_range(slots + 2, 1));
            endcase
            ex = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(4));
            send_add(8'($urandom), $urandom, per, ex);
        end
    endtask

    // Hold until every expected result has arrived, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_events.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        sb.reset_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (phase_values[p]) begin
            apb_write(phase_values[p]);
            if (p == 0) begin
                // zero period, slot overflow, zero runs with and without countdown
                send_add(8'd1, 32'd5, 16'd0, 16'd3);
                for (int k = 0; k < 9; k++)
                    send_add(8'(10 + k), 32'(1 + 4 * k), (k == 3) ? 16'hFFFF : 16'(k + 1),
                             16'(k % 4));
                send_add(8'd0, 32'd0, 16'd1, 16'd0);
                send_add(8'd200, 32'd4, 16'hFFFF, 16'd0);
                send_add(8'd255, 32'hFFFF_FFFF, 16'd2, 16'hFFFF);
                repeat (10) send_tick();
            end
            if (p == 2) hold_request = 1;
            repeat (30) random_item(sb.live_slots());
            drain();
        end
        if (sb.errors == 0 && sb.pending_events.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
